### hdl/vfc_pkg.sv
package vfc_pkg;

  // Widths of the linear cell index and of the memory address bus.
  localparam int IDX_W   = 17;
  localparam int ADDR_W  = 22;
  localparam int ENTRY_W = 11;

  // Voxel kinds.
  localparam logic [1:0] KIND_AIR  = 2'd0;
  localparam logic [1:0] KIND_CUBE = 2'd1;

  // Face directions.
  localparam logic [2:0] DIR_POS_X = 3'd0;
  localparam logic [2:0] DIR_POS_Y = 3'd1;
  localparam logic [2:0] DIR_NEG_X = 3'd2;
  localparam logic [2:0] DIR_NEG_Y = 3'd3;
  localparam logic [2:0] DIR_POS_Z = 3'd4;
  localparam logic [2:0] DIR_NEG_Z = 3'd5;

  // Texture rows.
  localparam logic [1:0] ROW_TOP    = 2'd0;
  localparam logic [1:0] ROW_SIDE   = 2'd1;
  localparam logic [1:0] ROW_BOTTOM = 2'd2;

  // Operations.
  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_GENERATE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SIZE_X      = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y      = 2'd1;
  localparam logic [1:0] CFG_FLOOR_COUNT = 2'd2;

  // Read sequence steps: the center cell, then one step per direction.
  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_LAST   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_READ,
    ST_LAST,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] data;
  } mem_req_t;

  typedef struct packed {
    logic             busy;
    logic [5:0]       sx;
    logic [5:0]       sy;
    logic [4:0]       sz;
    logic [11:0]      sxy;
    logic [IDX_W-1:0] total;
  } geom_t;

  typedef struct packed {
    logic        op;
    logic [13:0] idx;
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic        half;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [3:0]  z;
  } cmd_t;

  typedef struct packed {
    logic [4:0] x;
    logic [4:0] y;
    logic [3:0] z;
    logic [2:0] dir;
    logic [7:0] tag;
    logic       half;
    logic [1:0] row;
    logic       last;
  } face_t;

endpackage

### hdl/voxel_face_culling_core.sv
// Write item: stored at its transfer edge; writes can be taken every cycle while in_tready is high.
// Generate item: multiply, address, seven single-port reads (cell, six neighbors), evaluate;
// the faces are then loaded into the output register, one face per cycle while out_tready is high.
// The next item is taken only back in idle, reached early for an air cell or a cell outside the grid.
// Reset sets extents 32, 32, 16 and clears MAX_X*MAX_Y*MAX_Z entries with in_tready low; a
// register write holds in_tready low in its own cycle and until the derived products settle.
module voxel_face_culling_core import vfc_pkg::*; #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cell_index[13:0], voxel_kind[15:14], voxel_tag[23:16], half_flag[24],
  // cell_x[29:25], cell_y[34:30], cell_z[38:35], zero pad[39]
  input  logic [39:0] in_tdata,
  // operation[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // face_x[4:0], face_y[9:5], face_z[13:10], face_dir[16:14], face_tag[24:17],
  // face_half[25], texture_row[27:26], zero pad[31:28]
  output logic [31:0] out_tdata,
  output logic        out_tlast
);

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;

  geom_t              geom;
  cmd_t               cmd;
  face_t              face;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rdata;
  logic               store_busy;

  // Unpack the input transfer.
  always_comb begin
    cmd.op   = in_tuser;
    cmd.idx  = in_tdata[13:0];
    cmd.kind = in_tdata[15:14];
    cmd.tag  = in_tdata[23:16];
    cmd.half = in_tdata[24];
    cmd.x    = in_tdata[29:25];
    cmd.y    = in_tdata[34:30];
    cmd.z    = in_tdata[38:35];
  end

  vfc_geom #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .geom     (geom)
  );

  vfc_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mem_req),
    .rdata(rdata),
    .busy (store_busy)
  );

  vfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .store_busy(store_busy),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .face      (face)
  );

  // Pack the result transfer.
  assign out_tdata = {4'b0000, face.row, face.half, face.tag, face.dir, face.z, face.y, face.x};
  assign out_tlast = face.last;

  // No item is taken while the store is being cleared.
  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) store_busy |-> !in_tready
  ) else $error("input accepted during the clearing pass");

  // Memory writes happen only on an accepted write item.
  a_write_only_on_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (mem_req.en && mem_req.we) |-> (in_tvalid && in_tready && (in_tuser == OP_WRITE))
  ) else $error("memory write without an accepted write item");

  // The texture row agrees with the face direction.
  a_row_matches_dir: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (((face.dir == DIR_POS_Z) == (face.row == ROW_TOP)) &&
                    ((face.dir == DIR_NEG_Z) == (face.row == ROW_BOTTOM)))
  ) else $error("texture row does not match face direction");

endmodule

### hdl/vfc_store.sv
module vfc_store import vfc_pkg::*; #(
  parameter int DEPTH = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mem_req_t           req,
  output logic [ENTRY_W-1:0] rdata,
  output logic               busy
);

  localparam int AW = $clog2(DEPTH);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;
  logic [AW-1:0]      clr_cnt_r;
  logic               clearing_r;

  // Clearing pass after reset: one entry per cycle back to air.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Single-port memory with registered read data.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.en && req.we) begin
      mem[AW'(req.addr)] <= req.data;
    end
    if (req.en && !req.we) begin
      rdata_r <= mem[AW'(req.addr)];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clearing_r;

endmodule

### hdl/vfc_geom.sv
module vfc_geom import vfc_pkg::*; #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [5:0] cfg_wdata,
  output geom_t      geom
);

  logic [5:0]       size_x_r;
  logic [5:0]       size_y_r;
  logic [4:0]       floor_r;
  logic [1:0]       settle_r;
  logic [11:0]      sxy_r;
  logic [IDX_W-1:0] total_r;
  logic [5:0]       eff_x;
  logic [5:0]       eff_y;
  logic [4:0]       eff_z;

  // Register writes; settle_r keeps the block busy until the derived products have settled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 6'd32;
      size_y_r <= 6'd32;
      floor_r  <= 5'd16;
      settle_r <= 2'd2;
    end else begin
      if (cfg_we) begin
        settle_r <= 2'd2;
        unique case (cfg_addr)
          CFG_SIZE_X:      size_x_r <= cfg_wdata;
          CFG_SIZE_Y:      size_y_r <= cfg_wdata;
          CFG_FLOOR_COUNT: floor_r  <= cfg_wdata[4:0];
          default: ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // Extents above the built grid act as the built grid.
  always_comb begin
    eff_x = (32'(size_x_r) > MAX_X) ? 6'(MAX_X) : size_x_r;
    eff_y = (32'(size_y_r) > MAX_Y) ? 6'(MAX_Y) : size_y_r;
    eff_z = (32'(floor_r) > MAX_Z) ? 5'(MAX_Z) : floor_r;
  end

  // Floor area and cell count, one multiplier per stage.
  always_ff @(posedge clk) begin
    sxy_r   <= 12'(eff_x) * 12'(eff_y);
    total_r <= IDX_W'(sxy_r) * IDX_W'(eff_z);
  end

  always_comb begin
    geom.busy  = cfg_we || (settle_r != 2'd0);
    geom.sx    = eff_x;
    geom.sy    = eff_y;
    geom.sz    = eff_z;
    geom.sxy   = sxy_r;
    geom.total = total_r;
  end

endmodule

### hdl/vfc_ctrl.sv
module vfc_ctrl import vfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  geom_t              geom,
  input  logic               store_busy,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  cmd_t               cmd,
  output mem_req_t           mem_req,
  input  logic [ENTRY_W-1:0] rdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output face_t              face
);

  state_t           state_r;
  state_t           state_nxt;
  logic [2:0]       step_r;
  logic             pend_valid_r;
  logic [2:0]       pend_step_r;
  logic             pend_inb_r;
  logic [5:0]       mask_r;
  logic [4:0]       x_r;
  logic [4:0]       y_r;
  logic [3:0]       z_r;
  logic [10:0]      prod_y_r;
  logic [15:0]      prod_z_r;
  logic             inb_r;
  logic [IDX_W-1:0] base_r;
  logic [7:0]       tag_r;
  logic             half_r;
  logic             out_valid_r;
  face_t            face_r;

  logic             hs_in;
  logic             wr_ok;
  logic [IDX_W-1:0] nb_addr;
  logic             nb_inb;
  logic             proc_center;
  logic             center_air;
  logic             proc_face;
  logic [2:0]       pend_dir;
  logic             vis;
  logic [5:0]       mask_upd;
  logic             emit_load;
  logic [2:0]       sel;
  logic [5:0]       mask_rem;

  assign hs_in = in_tvalid && in_tready;
  assign wr_ok = (IDX_W'(cmd.idx) < geom.total);

  // Address and bounds of the cell read at the current step.
  always_comb begin
    nb_addr = base_r;
    nb_inb  = 1'b1;
    if (step_r != STEP_CENTER) begin
      unique case (step_r - 3'd1)
        DIR_POS_X: begin
          nb_addr = base_r + IDX_W'(1);
          nb_inb  = ({1'b0, x_r} + 6'd1) < geom.sx;
        end
        DIR_POS_Y: begin
          nb_addr = base_r + IDX_W'(geom.sx);
          nb_inb  = ({1'b0, y_r} + 6'd1) < geom.sy;
        end
        DIR_NEG_X: begin
          nb_addr = base_r - IDX_W'(1);
          nb_inb  = (x_r != 5'd0);
        end
        DIR_NEG_Y: begin
          nb_addr = base_r - IDX_W'(geom.sx);
          nb_inb  = (y_r != 5'd0);
        end
        DIR_POS_Z: begin
          nb_addr = base_r + IDX_W'(geom.sxy);
          nb_inb  = ({1'b0, z_r} + 5'd1) < geom.sz;
        end
        DIR_NEG_Z: begin
          nb_addr = base_r - IDX_W'(geom.sxy);
          nb_inb  = (z_r != 4'd0);
        end
        default: begin
          nb_addr = base_r;
          nb_inb  = 1'b0;
        end
      endcase
    end
  end

  // Evaluate the entry returned by the memory for the previous step.
  always_comb begin
    proc_center = pend_valid_r && (pend_step_r == STEP_CENTER);
    center_air  = proc_center && (rdata[1:0] == KIND_AIR);
    proc_face   = pend_valid_r && (pend_step_r != STEP_CENTER);
    pend_dir    = pend_step_r - 3'd1;
    vis = !pend_inb_r || (rdata[1:0] == KIND_AIR) ||
          ((pend_dir <= DIR_NEG_Y) && !half_r && (rdata[1:0] == KIND_CUBE) && rdata[10]);
    mask_upd = mask_r;
    if (proc_face && vis) begin
      mask_upd[pend_dir] = 1'b1;
    end
  end

  // Lowest pending face goes out first.
  always_comb begin
    sel = DIR_NEG_Z;
    for (int i = 5; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = 3'(i);
      end
    end
    mask_rem      = mask_r;
    mask_rem[sel] = 1'b0;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (hs_in && (cmd.op == OP_GENERATE)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = inb_r ? ST_READ : ST_IDLE;
      ST_READ: begin
        priority if (center_air) begin
          state_nxt = ST_IDLE;
        end else if (step_r == STEP_LAST) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: state_nxt = (mask_upd != 6'd0) ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (emit_load && (mask_rem == 6'd0)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: input handshake, memory requests, face loads.
  always_comb begin
    in_tready    = (state_r == ST_IDLE) && !store_busy && !geom.busy;
    emit_load    = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
    mem_req.en   = 1'b0;
    mem_req.we   = 1'b0;
    mem_req.addr = ADDR_W'(nb_addr);
    mem_req.data = {cmd.half, cmd.tag, cmd.kind};
    unique case (state_r)
      ST_IDLE: begin
        mem_req.en   = hs_in && (cmd.op == OP_WRITE) && wr_ok;
        mem_req.we   = 1'b1;
        mem_req.addr = ADDR_W'(cmd.idx);
      end
      ST_READ: mem_req.en = nb_inb;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      mask_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= (state_r == ST_READ) && !center_air;
      if (state_r == ST_ADDR) begin
        mask_r <= '0;
      end else if (emit_load) begin
        mask_r <= mask_rem;
      end else begin
        mask_r <= mask_upd;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers of the generate sequence.
  always_ff @(posedge clk) begin
    if (hs_in) begin
      x_r <= cmd.x;
      y_r <= cmd.y;
      z_r <= cmd.z;
    end
    if (state_r == ST_MUL) begin
      prod_y_r <= 11'(y_r) * 11'(geom.sx);
      prod_z_r <= 16'(z_r) * 16'(geom.sxy);
      inb_r    <= ({1'b0, x_r} < geom.sx) && ({1'b0, y_r} < geom.sy) &&
                  ({1'b0, z_r} < geom.sz);
    end
    if (state_r == ST_ADDR) begin
      base_r <= IDX_W'(x_r) + IDX_W'(prod_y_r) + IDX_W'(prod_z_r);
      step_r <= STEP_CENTER;
    end else if (state_r == ST_READ) begin
      step_r <= step_r + 3'd1;
    end
    pend_step_r <= step_r;
    pend_inb_r  <= nb_inb;
    if (proc_center) begin
      tag_r  <= rdata[9:2];
      half_r <= rdata[10];
    end
    if (emit_load) begin
      face_r.x    <= x_r;
      face_r.y    <= y_r;
      face_r.z    <= z_r;
      face_r.dir  <= sel;
      face_r.tag  <= tag_r;
      face_r.half <= half_r;
      face_r.row  <= (sel == DIR_POS_Z) ? ROW_TOP :
                     ((sel == DIR_NEG_Z) ? ROW_BOTTOM : ROW_SIDE);
      face_r.last <= (mask_rem == 6'd0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign face       = face_r;

endmodule

### sim/face_checker.sv
module face_checker import vfc_pkg::*; #(
  parameter int MAX_X = 32,
  parameter int MAX_Y = 32,
  parameter int MAX_Z = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // cell_index[13:0], voxel_kind[15:14], voxel_tag[23:16], half_flag[24],
  // cell_x[29:25], cell_y[34:30], cell_z[38:35], zero pad[39]
  input  logic [39:0] in_tdata,
  // operation[0]
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // face_x[4:0], face_y[9:5], face_z[13:10], face_dir[16:14], face_tag[24:17],
  // face_half[25], texture_row[27:26], zero pad[31:28]
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          faces_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tag;
    logic       half;
  } voxel_t;

  typedef struct packed {
    logic [4:0] x;
    logic [4:0] y;
    logic [3:0] z;
    logic [2:0] dir;
    logic [7:0] tag;
    logic       half;
    logic [1:0] row;
    logic       last;
  } face_rec_t;

  // Shadow copy of the voxel memory and of the extent registers.
  voxel_t     grid [DEPTH];
  logic [5:0] ext_x_reg;
  logic [5:0] ext_y_reg;
  logic [4:0] ext_z_reg;
  face_rec_t  expected_faces [$];

  function automatic int clip(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  // Returns 0 when the cell lies outside the configured grid.
  function automatic bit lookup_cell(int x, int y, int z, output voxel_t v);
    int sx, sy, sz;
    sx = clip(int'(ext_x_reg), MAX_X);
    sy = clip(int'(ext_y_reg), MAX_Y);
    sz = clip(int'(ext_z_reg), MAX_Z);
    v = '{KIND_AIR, 8'd0, 1'b0};
    if (x < 0 || y < 0 || z < 0 || x >= sx || y >= sy || z >= sz) return 1'b0;
    v = grid[x + y * sx + z * sx * sy];
    return 1'b1;
  endfunction

  // A face shows through an edge of the grid, through air, and on the side of a
  // full voxel next to a half-height cube.
  function automatic bit face_open(int x, int y, int z, bit full_side);
    voxel_t n;
    if (!lookup_cell(x, y, z, n)) return 1'b1;
    if (n.kind == KIND_AIR) return 1'b1;
    return full_side && n.kind == KIND_CUBE && n.half;
  endfunction

  task automatic store_voxel(input int idx, input voxel_t v);
    int total;
    total = clip(int'(ext_x_reg), MAX_X) * clip(int'(ext_y_reg), MAX_Y) *
            clip(int'(ext_z_reg), MAX_Z);
    if (idx < total) grid[idx] = v;
  endtask

  task automatic predict_faces(input int x, input int y, input int z);
    voxel_t    c;
    face_rec_t f;
    face_rec_t found [$];
    int        dx, dy, dz;
    bit        side;
    if (!lookup_cell(x, y, z, c)) return;
    if (c.kind == KIND_AIR) return;
    for (int d = int'(DIR_POS_X); d <= int'(DIR_NEG_Z); d++) begin
      dx = 0;
      dy = 0;
      dz = 0;
      side = 1'b1;
      case (d[2:0])
        DIR_POS_X: dx = 1;
        DIR_POS_Y: dy = 1;
        DIR_NEG_X: dx = -1;
        DIR_NEG_Y: dy = -1;
        DIR_POS_Z: begin
          dz = 1;
          side = 1'b0;
        end
        default: begin
          dz = -1;
          side = 1'b0;
        end
      endcase
      if (face_open(x + dx, y + dy, z + dz, side && !c.half)) begin
        f.x = 5'(x);
        f.y = 5'(y);
        f.z = 4'(z);
        f.dir = d[2:0];
        f.tag = c.tag;
        f.half = c.half;
        f.row = (d[2:0] == DIR_POS_Z) ? ROW_TOP : (d[2:0] == DIR_NEG_Z) ? ROW_BOTTOM : ROW_SIDE;
        f.last = 1'b0;
        found.push_back(f);
      end
    end
    if (found.size() > 0) begin
      f = found.pop_back();
      f.last = 1'b1;
      found.push_back(f);
    end
    foreach (found[i]) expected_faces.push_back(found[i]);
  endtask

  function automatic string describe(face_rec_t f);
    return $sformatf("x=%0d y=%0d z=%0d dir=%0d tag=%0d half=%0d row=%0d last=%0d",
                     f.x, f.y, f.z, f.dir, f.tag, f.half, f.row, f.last);
  endfunction

  // Watch all three ports on the rising edge.
  always @(posedge clk) begin : watch
    face_rec_t got;
    face_rec_t want;
    if (!rst_n) begin
      foreach (grid[i]) grid[i] = '{KIND_AIR, 8'd0, 1'b0};
      ext_x_reg = 6'd32;
      ext_y_reg = 6'd32;
      ext_z_reg = 5'd16;
      expected_faces.delete();
      fail_count = 0;
      faces_checked = 0;
    end else begin
      // Compare each face transfer with the oldest expected face.
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[4:0];
        got.y = out_tdata[9:5];
        got.z = out_tdata[13:10];
        got.dir = out_tdata[16:14];
        got.tag = out_tdata[24:17];
        got.half = out_tdata[25];
        got.row = out_tdata[27:26];
        got.last = out_tlast;
        faces_checked++;
        if (expected_faces.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected face at %0t: %s", $time, describe(got));
        end else begin
          want = expected_faces.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("face mismatch at %0t: expected %s", $time, describe(want));
              $display("                       actual %s", describe(got));
            end
          end
        end
      end

      // Register writes update the shadow extents.
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SIZE_X:      ext_x_reg = cfg_wdata;
          CFG_SIZE_Y:      ext_y_reg = cfg_wdata;
          CFG_FLOOR_COUNT: ext_z_reg = cfg_wdata[4:0];
          default: ;
        endcase
      end

      // Each accepted item either updates the store or queues its faces.
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_WRITE) begin
          store_voxel(int'(in_tdata[13:0]), '{in_tdata[15:14], in_tdata[23:16], in_tdata[24]});
        end else begin
          predict_faces(int'(in_tdata[29:25]), int'(in_tdata[34:30]), int'(in_tdata[38:35]));
        end
      end
    end
    pending = expected_faces.size();
  end

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vfc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [5:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;

  int fail_count;
  int pending;
  int faces_checked;

  // Effective extents as the block sees them.
  int cur_x;
  int cur_y;
  int cur_z;
  int burst_left;
  int n_writes;
  int n_gens;
  int n_settings;
  bit hold_req;

  voxel_face_culling_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  face_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .faces_checked (faces_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic int clip(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [13:0] lin(int x, int y, int z);
    return 14'(x + y * cur_x + z * cur_x * cur_y);
  endfunction

  // Offers one item; bursts of transfers are separated by random gaps.
  task automatic send_item(input logic op, input logic [13:0] idx, input logic [1:0] kind,
                           input logic [7:0] tag, input logic half, input logic [4:0] x,
                           input logic [4:0] y, input logic [3:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, z, y, x, half, tag, kind, idx};
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    @(negedge clk);
  endtask

  // The fields a write does not use carry random values.
  task automatic write_voxel(input logic [13:0] idx, input logic [1:0] kind,
                             input logic [7:0] tag, input logic half);
    n_writes++;
    send_item(OP_WRITE, idx, kind, tag, half, 5'($urandom_range(0, 31)),
              5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
  endtask

  task automatic gen_cell(input int x, input int y, input int z);
    n_gens++;
    send_item(OP_GENERATE, 14'($urandom_range(0, 16383)), 2'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 5'(x), 5'(y), 4'(z));
  endtask

  // Wait until every face has arrived and the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_extents(input int sx, input int sy, input int sz);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SIZE_X;
    cfg_wdata <= 6'(sx);
    @(negedge clk);
    cfg_addr  <= CFG_SIZE_Y;
    cfg_wdata <= 6'(sy);
    @(negedge clk);
    cfg_addr  <= CFG_FLOOR_COUNT;
    cfg_wdata <= 6'(sz);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_x = clip(sx, 32);
    cur_y = clip(sy, 32);
    cur_z = clip(sz % 32, 16);
    n_settings++;
  endtask

  // Receiver: stall patterns that change now and then, plus one long hold-off.
  initial begin
    int mode;
    int mode_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_done = 1'b0;
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus.
  initial begin
    int r, x, y, z, wx, wy, wz, bx, by, bz;
    logic [1:0] kind;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_WRITE;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_SIZE_X;
    cfg_wdata  = '0;
    rst_n      = 1'b0;
    hold_req   = 1'b0;
    burst_left = 0;
    n_writes   = 0;
    n_gens     = 0;
    n_settings = 0;
    cur_x = 32;
    cur_y = 32;
    cur_z = 16;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: air cell, corner cells, and a cross of neighbors around (5,5,5).
    gen_cell(0, 0, 0);
    write_voxel(0, KIND_CUBE, 8'hFF, 1'b0);
    gen_cell(0, 0, 0);
    write_voxel(16383, 2'd3, 8'h00, 1'b1);
    gen_cell(31, 31, 15);
    write_voxel(lin(5, 5, 5), KIND_CUBE, 8'hA5, 1'b0);
    write_voxel(lin(6, 5, 5), KIND_CUBE, 8'h3C, 1'b1);
    write_voxel(lin(5, 6, 5), 2'd2, 8'h11, 1'b1);
    write_voxel(lin(4, 5, 5), 2'd3, 8'h22, 1'b0);
    write_voxel(lin(5, 5, 6), KIND_CUBE, 8'h33, 1'b1);
    write_voxel(lin(5, 5, 4), KIND_CUBE, 8'h44, 1'b0);
    gen_cell(5, 5, 5);
    gen_cell(6, 5, 5);
    // A half-height cell ignores a half-height neighbor on its sides.
    write_voxel(lin(5, 5, 5), KIND_CUBE, 8'h5A, 1'b1);
    gen_cell(5, 5, 5);
    write_voxel(lin(5, 5, 5), KIND_AIR, 8'h77, 1'b0);
    gen_cell(5, 5, 5);

    // Tiny grid: writes and generates beyond its edge are dropped.
    set_extents(2, 3, 1);
    write_voxel(5, KIND_CUBE, 8'h81, 1'b0);
    write_voxel(6, KIND_CUBE, 8'h99, 1'b0);
    gen_cell(1, 2, 0);
    gen_cell(2, 0, 0);

    // Empty grid, then oversized extents that act as the maximum.
    set_extents(0, 5, 5);
    write_voxel(0, KIND_CUBE, 8'h01, 1'b0);
    gen_cell(0, 0, 0);
    set_extents(63, 63, 31);
    gen_cell(0, 0, 0);
    gen_cell(5, 0, 0);

    // Random phases: writes and generates mostly inside a small moving box.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       set_extents(32, 32, 16);
        1:       set_extents(4, 3, 2);
        2:       set_extents(1, 1, 1);
        3:       set_extents(63, 7, 31);
        4:       set_extents(1, 32, 1);
        5:       set_extents(32, 1, 3);
        default: set_extents($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(1, 4));
      endcase
      if (p == 1) hold_req = 1'b1;
      wx = clip(cur_x, 3);
      wy = clip(cur_y, 3);
      wz = clip(cur_z, 3);
      bx = 0;
      by = 0;
      bz = 0;
      for (int i = 0; i < 32; i++) begin
        if (i % 12 == 0) begin
          bx = $urandom_range(0, cur_x - wx);
          by = $urandom_range(0, cur_y - wy);
          bz = $urandom_range(0, cur_z - wz);
        end
        x = bx + $urandom_range(0, wx - 1);
        y = by + $urandom_range(0, wy - 1);
        z = bz + $urandom_range(0, wz - 1);
        r = $urandom_range(0, 99);
        if (r < 45) begin
          case ($urandom_range(0, 9))
            0, 1:       kind = KIND_AIR;
            2, 3, 4, 5: kind = KIND_CUBE;
            6, 7:       kind = 2'd2;
            default:    kind = 2'd3;
          endcase
          write_voxel(lin(x, y, z), kind, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end else if (r < 55) begin
          write_voxel(14'($urandom_range(0, 16383)), 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (r < 90) begin
          gen_cell(x, y, z);
        end else begin
          gen_cell($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15));
        end
      end
    end

    // Drain and give the verdict.
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("tb summary: %0d voxel writes and %0d generate requests over %0d extent settings,",
             n_writes, n_gens, n_settings);
    $display("tb summary: %0d face records compared", faces_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
